// File: rtl/snrf_pkg.sv
`default_nettype none

package snrf_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int SERIAL_W = 32;
    localparam int CAP_W    = 7;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(50);

    // Requests from the front end to the window store
    typedef struct packed {
        logic check;   // compare a serial and record it if new
        logic clear;   // empty the window
    } snrf_req_t;

    // Map the programmed capacity onto the store: zero acts as one,
    // anything above the depth saturates.
    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0)
        begin
            res = CNT_W'(1);
        end
        else if (32'(cap) > WINDOW_DEPTH)
        begin
            res = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/serial_number_replay_filter.sv
`default_nettype none

// Replay filter for 32-bit command serial numbers. Each serial beat is
// checked against the most recently recorded serials (up to window_capacity
// of them, 1 to 64; zero acts as 1 and larger values as 64) and answered with
// accepted = 1 if it was new and has now been recorded, or 0 if it is a
// repeat, which leaves the window untouched. When the window is full the
// oldest serial is dropped to make room. One serial is taken every cycle
// while serial_stall is low; each beat is held in the input register feeding
// the single compare-and-record stage that checks all 64 window entries in
// parallel before the result register. Writing window_capacity empties the
// window and must only be done while no beat is in flight.
module serial_number_replay_filter (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 window_capacity_wr,
    input  wire logic [snrf_pkg::CAP_W-1:0]     window_capacity,
    input  wire                                 serial_valid,
    output logic                                serial_stall,
    input  wire logic signed [snrf_pkg::SERIAL_W-1:0] serial_number,
    output logic                                result_valid,
    input  wire                                 result_stall,
    output logic                                accepted
);
    import snrf_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [SERIAL_W-1:0] s1_serial_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic                accepted_reg;
    logic [CNT_W-1:0]    cap_reg;
    logic                advance;
    logic                take;
    logic                hit;
    snrf_req_t           req;

    // Move the held beat on when the result register is free or draining
    assign advance      = !result_valid_reg || !result_stall;
    assign serial_stall = s1_valid_reg && !advance;
    assign take         = serial_valid && !serial_stall;

    // Request fields in order: check, clear
    assign req = {s1_valid_reg && advance, window_capacity_wr};

    snrf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .serial   (s1_serial_reg),
        .capacity (cap_reg),
        .hit      (hit)
    );

    // Next state of the two stages
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (req.check)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            cap_reg          <= eff_capacity(CAP_RESET);
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (window_capacity_wr)
            begin
                cap_reg <= eff_capacity(window_capacity);
            end
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_serial_reg <= serial_number;
        end
        if (req.check)
        begin
            accepted_reg <= !hit;
        end
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;

endmodule

`default_nettype wire

// File: rtl/snrf_window.sv
`default_nettype none

module snrf_window (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire snrf_pkg::snrf_req_t             req,
    input  wire logic [snrf_pkg::SERIAL_W-1:0]   serial,
    input  wire logic [snrf_pkg::CNT_W-1:0]      capacity,
    output logic                                 hit
);
    import snrf_pkg::*;

    logic [SERIAL_W-1:0] entries_reg [WINDOW_DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    oldest_reg;
    logic [IDX_W-1:0]    oldest_next;
    logic [WINDOW_DEPTH-1:0] match;
    logic [IDX_W-1:0]    wr_slot;
    logic                full;
    logic                record;

    // Compare the serial with every entry that lies inside the live window
    always_comb
    begin
        logic [IDX_W-1:0] offset;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            offset   = IDX_W'(i) - oldest_reg;
            match[i] = ({1'b0, offset} < count_reg) && (entries_reg[i] == serial);
        end
    end

    assign hit     = |match;
    assign record  = req.check && !hit;
    assign full    = (count_reg >= capacity);
    // The new serial lands just past the newest entry; when full the oldest
    // entry is dropped from the window at the same time.
    assign wr_slot = oldest_reg + count_reg[IDX_W-1:0];

    // Advance the oldest pointer (when full) or the count on a recorded serial, drop all on clear
    always_comb
    begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        if (req.clear)
        begin
            count_next  = '0;
            oldest_next = '0;
        end
        else if (record)
        begin
            if (full)
            begin
                oldest_next = oldest_reg + IDX_W'(1);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
        end
    end

    // Store the new serial
    always_ff @(posedge clk)
    begin
        if (record)
        begin
            entries_reg[wr_slot] <= serial;
        end
    end

endmodule

`default_nettype wire

// File: rtl/snrf_checker.sv
`default_nettype none

module snrf_checker (
    input wire clk,
    input wire rst_n,
    input wire serial_valid,
    input wire serial_stall,
    input wire result_valid,
    input wire result_stall,
    input wire accepted
);

    // Input back-pressure only ever comes from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        serial_stall |-> result_valid)
    else $error("serial stalled with no result pending");

    // A fresh result needs a matching serial beat taken earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(serial_valid && !serial_stall, 2))
    else $error("result appeared without a matching serial beat");

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(accepted))
    else $error("stalled result changed");

endmodule

bind serial_number_replay_filter snrf_checker u_snrf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .serial_valid (serial_valid),
    .serial_stall (serial_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted)
);

`default_nettype wire

// File: tb/serial_number_replay_filter_tb.sv
`timescale 1ns / 1ps

module serial_number_replay_filter_tb;

    import snrf_pkg::*;

    localparam int  CLK_HALF     = 10;
    localparam int  RESET_CYCLES = 6;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE       = 8;
    localparam int  LONG_HOLD    = 200;
    localparam int  PHASES       = 12;
    localparam int  PHASE_BEATS  = 113;
    localparam int  POOL_SIZE    = 160;
    localparam int  FLOOD_PHASE  = 2;
    localparam int  PAUSE_PHASE  = 5;
    localparam int  DIR_ROWS     = 31;
    localparam int  VERDICT_SLOTS = 16;

    localparam logic NEW_SERIAL = 1'b1;
    localparam logic REPLAY     = 1'b0;

    typedef enum logic { ROW_SERIAL, ROW_CAPACITY } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [SERIAL_W-1:0]   value;
        logic                  typed;
        logic                  verdict;
    } dir_row_t;

    typedef struct {
        logic [SERIAL_W-1:0] serial;
        logic                verdict;
    } verdict_t;

    logic                       clk;
    logic                       rst_n;
    logic                       window_capacity_wr;
    logic [CAP_W-1:0]           window_capacity;
    logic                       serial_valid;
    logic                       serial_stall;
    logic signed [SERIAL_W-1:0] serial_number;
    logic                       result_valid;
    logic                       result_stall;
    logic                       accepted;

    // Shadow of the window
    logic [SERIAL_W-1:0] shadow_store [WINDOW_DEPTH];
    int                  shadow_count;
    int                  shadow_head;
    logic [CAP_W-1:0]    shadow_capacity;

    // Ring of outstanding verdicts, in beat order
    verdict_t            expected_verdicts [VERDICT_SLOTS];
    int                  exp_wr;
    int                  exp_rd;
    logic [SERIAL_W-1:0] serial_pool [POOL_SIZE];
    int                  mismatches;
    int                  cycle_count;
    bit                  flood_on;
    bit                  hold_done;

    // Directed rows: extremes, neighbours, zero and saturated capacity, clearing
    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, REPLAY},
        '{ROW_SERIAL,   32'h7FFF_FFFF, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h8000_0000, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'hFFFF_FFFF, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'hFFFF_FFFE, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h8000_0000, 1'b1, REPLAY},
        '{ROW_SERIAL,   32'hFFFF_FFFF, 1'b1, REPLAY},
        '{ROW_CAPACITY, 32'd0,         1'b0, REPLAY},
        '{ROW_SERIAL,   32'h1234_5678, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h1234_5678, 1'b1, REPLAY},
        '{ROW_SERIAL,   32'h0A5A_5A5A, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h1234_5678, 1'b0, REPLAY},
        '{ROW_CAPACITY, 32'd127,       1'b0, REPLAY},
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h7FFF_FFFF, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, REPLAY},
        '{ROW_CAPACITY, 32'd1,         1'b0, REPLAY},
        '{ROW_SERIAL,   32'h5555_5555, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'hAAAA_AAAA, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h5555_5555, 1'b0, REPLAY},
        '{ROW_CAPACITY, 32'd2,         1'b0, REPLAY},
        '{ROW_SERIAL,   32'h0000_0001, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h0000_0002, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h0000_0001, 1'b0, REPLAY},
        '{ROW_SERIAL,   32'h0000_0003, 1'b0, REPLAY},
        '{ROW_SERIAL,   32'h0000_0001, 1'b0, REPLAY},
        '{ROW_CAPACITY, 32'd64,        1'b0, REPLAY},
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, NEW_SERIAL},
        '{ROW_SERIAL,   32'h0000_0000, 1'b1, REPLAY},
        '{ROW_SERIAL,   32'hFFFF_FFFF, 1'b1, NEW_SERIAL}
    };

    // Capacity written at the start of each random phase
    logic [CAP_W-1:0] phase_capacity [PHASES] = '{
        7'd50, 7'd64, 7'd65, 7'd3, 7'd127, 7'd0, 7'd63, 7'd2, 7'd1, 7'd17, 7'd100, 7'd50
    };

    serial_number_replay_filter u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .window_capacity_wr (window_capacity_wr),
        .window_capacity    (window_capacity),
        .serial_valid       (serial_valid),
        .serial_stall       (serial_stall),
        .serial_number      (serial_number),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .accepted           (accepted)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Clamp the programmed capacity onto the store depth
    function automatic int capacity_limit(input logic [CAP_W-1:0] cap);
        int lim;
        lim = int'(cap);
        if (lim == 0)
        begin
            lim = 1;
        end
        if (lim > WINDOW_DEPTH)
        begin
            lim = WINDOW_DEPTH;
        end
        return lim;
    endfunction

    // Look the serial up in the shadow window; record it if new
    function automatic logic window_lookup(input logic [SERIAL_W-1:0] serial);
        int lim;
        int slot;
        lim = capacity_limit(shadow_capacity);
        for (int i = 0; i < shadow_count; i++)
        begin
            slot = (shadow_head + i) % WINDOW_DEPTH;
            if (shadow_store[slot] == serial)
            begin
                return REPLAY;
            end
        end
        // drop the oldest entries until there is room
        while (shadow_count >= lim && shadow_count > 0)
        begin
            shadow_head  = (shadow_head + 1) % WINDOW_DEPTH;
            shadow_count = shadow_count - 1;
        end
        slot = (shadow_head + shadow_count) % WINDOW_DEPTH;
        shadow_store[slot] = serial;
        shadow_count = shadow_count + 1;
        return NEW_SERIAL;
    endfunction

    // Offer one serial beat and hold it until taken
    task automatic offer_serial(input logic [SERIAL_W-1:0] serial, input logic typed,
                                input logic typed_verdict);
        verdict_t v;
        serial_valid  <= 1'b1;
        serial_number <= serial;
        do
        begin
            @(posedge clk);
        end
        while (serial_stall);
        v.serial  = serial;
        v.verdict = window_lookup(serial);
        if (typed)
        begin
            v.verdict = typed_verdict;
        end
        expected_verdicts[exp_wr % VERDICT_SLOTS] = v;
        exp_wr = exp_wr + 1;
    endtask

    // Lower valid for a gap of the given length
    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            serial_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding verdict
    task automatic drain_results();
        serial_valid <= 1'b0;
        while (exp_wr != exp_rd)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Program the capacity while idle; this empties the window
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        window_capacity_wr <= 1'b1;
        window_capacity    <= cap;
        @(posedge clk);
        window_capacity_wr <= 1'b0;
        shadow_capacity = cap;
        shadow_count    = 0;
        shadow_head     = 0;
        @(posedge clk);
    endtask

    function automatic logic [SERIAL_W-1:0] pick_serial(input int pool_span);
        logic [SERIAL_W-1:0] s;
        int                  roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            s = $urandom;
        end
        else if (roll == 1)
        begin
            s = serial_pool[$urandom_range(0, 3)];
        end
        else
        begin
            s = serial_pool[$urandom_range(0, pool_span - 1)];
        end
        return s;
    endfunction

    // Stimulus
    initial
    begin : sender
        int pool_span;
        int burst_left;
        int max_gap;
        int max_burst;

        rst_n              = 1'b0;
        window_capacity_wr = 1'b0;
        window_capacity    = '0;
        serial_valid       = 1'b0;
        serial_number      = '0;
        flood_on           = 1'b0;
        shadow_capacity    = CAP_RESET;
        shadow_count       = 0;
        shadow_head        = 0;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            serial_pool[i] = $urandom;
        end
        serial_pool[0] = 32'h0000_0000;
        serial_pool[1] = 32'hFFFF_FFFF;
        serial_pool[2] = 32'h8000_0000;
        serial_pool[3] = 32'h7FFF_FFFF;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_table[r].kind == ROW_CAPACITY)
            begin
                write_capacity(dir_table[r].value[CAP_W-1:0]);
            end
            else
            begin
                offer_serial(dir_table[r].value, dir_table[r].typed, dir_table[r].verdict);
                idle_sender($urandom_range(0, 2));
            end
        end

        // random phases, one capacity each
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_capacity[p]);
            pool_span  = $urandom_range(1, 2 * capacity_limit(phase_capacity[p]) + 4);
            if (pool_span > POOL_SIZE)
            begin
                pool_span = POOL_SIZE;
            end
            max_gap    = (p % 4 == 3) ? 0 : $urandom_range(1, 8);
            max_burst  = $urandom_range(1, 24);
            burst_left = 0;
            if (p == FLOOD_PHASE)
            begin
                flood_on = 1'b1;
                max_gap  = 0;
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (p == PAUSE_PHASE && n == PHASE_BEATS / 2)
                begin
                    drain_results();
                end
                if (burst_left == 0)
                begin
                    idle_sender($urandom_range(0, max_gap));
                    burst_left = $urandom_range(1, max_burst);
                end
                offer_serial(pick_serial(pool_span), 1'b0, REPLAY);
                burst_left = burst_left - 1;
            end
            flood_on = 1'b0;
        end

        drain_results();
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: stall patterns, plus one long hold-off while flooding
    initial
    begin : receiver
        int mode;
        int span;
        hold_done    = 1'b0;
        result_stall = 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (!rst_n);
        forever
        begin
            if (flood_on && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            for (int k = 0; k < span; k++)
            begin
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= (k % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each taken result beat with the oldest verdict
    always @(posedge clk)
    begin : verdict_check
        verdict_t v;
        if (rst_n && result_valid && !result_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result beat, accepted=%0b", $time, accepted);
                mismatches = mismatches + 1;
            end
            else
            begin
                v = expected_verdicts[exp_rd % VERDICT_SLOTS];
                exp_rd = exp_rd + 1;
                if (accepted !== v.verdict)
                begin
                    $display("%0t: serial %h accepted expected %0b, actual %0b",
                             $time, v.serial, v.verdict, accepted);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Guard against a hung handshake
    initial
    begin
        mismatches  = 0;
        cycle_count = 0;
        exp_wr      = 0;
        exp_rd      = 0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d verdicts outstanding", $time,
                     exp_wr - exp_rd);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/snrf_pkg.sv
rtl/snrf_window.sv
rtl/serial_number_replay_filter.sv
rtl/snrf_checker.sv
tb/serial_number_replay_filter_tb.sv
